### src/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes,
// sequencer states, control word format and the microcode table.
// No dependencies.
package rau_pkg;

  localparam int W = 32;
  localparam int CntW = $clog2(W);
  localparam int PcW = 5;

  // Operation codes carried on op_i.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_SIMP = 2'd2;
  localparam logic [1:0] OP_QUOT = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  typedef enum logic [3:0] {
    SRC_NA, SRC_DA, SRC_NB, SRC_DB, SRC_GA, SRC_GB, SRC_M, SRC_T, SRC_NR, SRC_ONE
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_GA, DST_GB, DST_M, DST_T, DST_NR, DST_DR
  } dst_e;

  typedef enum logic [2:0] {
    ALU_NONE, ALU_PASS, ALU_ADD, ALU_MUL, ALU_DIVQ, ALU_DIVR
  } alu_e;

  typedef enum logic [2:0] {
    C_NEXT,   // fall through
    C_GOTO,   // unconditional jump
    C_EQ,     // jump if a == b
    C_ZERO,   // jump if a == 0
    C_ANYZ,   // jump if a == 0 or b == 0
    C_FIN,    // transaction done, result in NR/DR
    C_FAIL    // transaction done with divide error
  } cond_e;

  typedef struct packed {
    alu_e             alu;
    src_e             srca;
    src_e             srcb;
    dst_e             dst;
    logic             swap;   // GA <= GB alongside the write (Euclid step)
    cond_e            cond;
    logic [PcW-1:0]   target;
  } uword_t;

  // Program entry points and labels.
  localparam logic [PcW-1:0] PC_ADD   = 5'd0;
  localparam logic [PcW-1:0] PC_AGCD  = 5'd4;
  localparam logic [PcW-1:0] PC_ALCM  = 5'd6;
  localparam logic [PcW-1:0] PC_ADDEQ = 5'd15;
  localparam logic [PcW-1:0] PC_MUL   = 5'd17;
  localparam logic [PcW-1:0] PC_SIMP  = 5'd19;
  localparam logic [PcW-1:0] PC_SGCD  = 5'd21;
  localparam logic [PcW-1:0] PC_SDIV  = 5'd23;
  localparam logic [PcW-1:0] PC_QUOT  = 5'd26;
  localparam logic [PcW-1:0] PC_FAIL  = 5'd29;

  function automatic uword_t uw(alu_e alu, src_e a, src_e b, dst_e d, logic sw,
                                cond_e c, logic [PcW-1:0] tgt);
    uword_t w;
    w.alu    = alu;
    w.srca   = a;
    w.srcb   = b;
    w.dst    = d;
    w.swap   = sw;
    w.cond   = c;
    w.target = tgt;
    return w;
  endfunction

  function automatic logic [PcW-1:0] entry(logic [1:0] op);
    logic [PcW-1:0] pc;
    unique case (op)
      OP_ADD:  pc = PC_ADD;
      OP_MUL:  pc = PC_MUL;
      OP_SIMP: pc = PC_SIMP;
      OP_QUOT: pc = PC_QUOT;
      default: pc = PC_FAIL;
    endcase
    return pc;
  endfunction

  // Microcode ROM.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // add
      5'd0:  w = uw(ALU_NONE, SRC_DA, SRC_DB, DST_NONE, 1'b0, C_EQ,   PC_ADDEQ);
      5'd1:  w = uw(ALU_NONE, SRC_DA, SRC_DB, DST_NONE, 1'b0, C_ANYZ, PC_FAIL);
      5'd2:  w = uw(ALU_PASS, SRC_DA, SRC_DB, DST_GA,   1'b0, C_NEXT, PC_FAIL);
      5'd3:  w = uw(ALU_PASS, SRC_DB, SRC_DB, DST_GB,   1'b0, C_NEXT, PC_FAIL);
      5'd4:  w = uw(ALU_NONE, SRC_GB, SRC_GB, DST_NONE, 1'b0, C_ZERO, PC_ALCM);
      5'd5:  w = uw(ALU_DIVR, SRC_GA, SRC_GB, DST_GB,   1'b1, C_GOTO, PC_AGCD);
      5'd6:  w = uw(ALU_NONE, SRC_GA, SRC_GA, DST_NONE, 1'b0, C_ZERO, PC_FAIL);
      5'd7:  w = uw(ALU_MUL,  SRC_DA, SRC_DB, DST_T,    1'b0, C_NEXT, PC_FAIL);
      5'd8:  w = uw(ALU_DIVQ, SRC_T,  SRC_GA, DST_M,    1'b0, C_NEXT, PC_FAIL);
      5'd9:  w = uw(ALU_DIVQ, SRC_M,  SRC_DA, DST_T,    1'b0, C_NEXT, PC_FAIL);
      5'd10: w = uw(ALU_MUL,  SRC_NA, SRC_T,  DST_NR,   1'b0, C_NEXT, PC_FAIL);
      5'd11: w = uw(ALU_DIVQ, SRC_M,  SRC_DB, DST_T,    1'b0, C_NEXT, PC_FAIL);
      5'd12: w = uw(ALU_MUL,  SRC_NB, SRC_T,  DST_T,    1'b0, C_NEXT, PC_FAIL);
      5'd13: w = uw(ALU_ADD,  SRC_NR, SRC_T,  DST_NR,   1'b0, C_NEXT, PC_FAIL);
      5'd14: w = uw(ALU_PASS, SRC_M,  SRC_M,  DST_DR,   1'b0, C_FIN,  PC_FAIL);
      5'd15: w = uw(ALU_ADD,  SRC_NA, SRC_NB, DST_NR,   1'b0, C_NEXT, PC_FAIL);
      5'd16: w = uw(ALU_PASS, SRC_DA, SRC_DA, DST_DR,   1'b0, C_FIN,  PC_FAIL);
      // multiply
      5'd17: w = uw(ALU_MUL,  SRC_NA, SRC_NB, DST_NR,   1'b0, C_NEXT, PC_FAIL);
      5'd18: w = uw(ALU_MUL,  SRC_DA, SRC_DB, DST_DR,   1'b0, C_FIN,  PC_FAIL);
      // simplify
      5'd19: w = uw(ALU_PASS, SRC_NA, SRC_NA, DST_GA,   1'b0, C_NEXT, PC_FAIL);
      5'd20: w = uw(ALU_PASS, SRC_DA, SRC_DA, DST_GB,   1'b0, C_NEXT, PC_FAIL);
      5'd21: w = uw(ALU_NONE, SRC_GB, SRC_GB, DST_NONE, 1'b0, C_ZERO, PC_SDIV);
      5'd22: w = uw(ALU_DIVR, SRC_GA, SRC_GB, DST_GB,   1'b1, C_GOTO, PC_SGCD);
      5'd23: w = uw(ALU_NONE, SRC_GA, SRC_GA, DST_NONE, 1'b0, C_ZERO, PC_FAIL);
      5'd24: w = uw(ALU_DIVQ, SRC_NA, SRC_GA, DST_NR,   1'b0, C_NEXT, PC_FAIL);
      5'd25: w = uw(ALU_DIVQ, SRC_DA, SRC_GA, DST_DR,   1'b0, C_FIN,  PC_FAIL);
      // integer quotient
      5'd26: w = uw(ALU_NONE, SRC_DA, SRC_DA, DST_NONE, 1'b0, C_ZERO, PC_FAIL);
      5'd27: w = uw(ALU_DIVQ, SRC_NA, SRC_DA, DST_NR,   1'b0, C_NEXT, PC_FAIL);
      5'd28: w = uw(ALU_PASS, SRC_ONE, SRC_ONE, DST_DR, 1'b0, C_FIN,  PC_FAIL);
      default: w = uw(ALU_NONE, SRC_NA, SRC_NA, DST_NONE, 1'b0, C_FAIL, PC_FAIL);
    endcase
    return w;
  endfunction

endpackage

### src/rau_div.sv
// Serial signed divider, truncating quotient and dividend-signed remainder.
// One quotient bit per cycle, restoring. Uses rau_pkg.
module rau_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [rau_pkg::W-1:0] dividend_i,
  input  logic [rau_pkg::W-1:0] divisor_i,
  output logic                  done_o,
  output logic [rau_pkg::W-1:0] quot_o,
  output logic [rau_pkg::W-1:0] rem_o
);

  logic                     run_q, fin_q, done_q;
  logic [rau_pkg::CntW-1:0] cnt_q;
  logic [rau_pkg::W-1:0]    rem_q, rem_d, shf_q, shf_d, dvs_q, quot_q, remo_q;
  logic                     negq_q, negr_q;
  logic [rau_pkg::W:0]      trial;

  localparam logic [rau_pkg::CntW-1:0] CntLast = rau_pkg::CntW'(rau_pkg::W - 1);

  always_comb begin
    trial = {rem_q, shf_q[rau_pkg::W-1]} - {1'b0, dvs_q};
    if (!trial[rau_pkg::W]) begin
      rem_d = trial[rau_pkg::W-1:0];
      shf_d = {shf_q[rau_pkg::W-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[rau_pkg::W-2:0], shf_q[rau_pkg::W-1]};
      shf_d = {shf_q[rau_pkg::W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && (cnt_q == CntLast);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // magnitudes are loaded, sign fix-up happens once at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      shf_q  <= dividend_i[rau_pkg::W-1] ? -dividend_i : dividend_i;
      dvs_q  <= divisor_i[rau_pkg::W-1] ? -divisor_i : divisor_i;
      negq_q <= dividend_i[rau_pkg::W-1] ^ divisor_i[rau_pkg::W-1];
      negr_q <= dividend_i[rau_pkg::W-1];
    end else if (run_q) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
    end
    if (fin_q) begin
      quot_q <= negq_q ? -shf_q : shf_q;
      remo_q <= negr_q ? -rem_q : rem_q;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = remo_q;

endmodule

### src/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: microcoded sequencer and datapath.
// Depends on rau_pkg (types, microcode ROM) and rau_div (serial divider).
//
// Usage: drive op_i and the two fractions A = num_a_i/den_a_i and
// B = num_b_i/den_b_i, raise start while busy is low; that edge takes the
// transaction. busy stays high until the result is ready. The result shows
// up on num_r_o/den_r_o/div_error_o for exactly one cycle with done_o high;
// the receiver must take it then, it is not held. Outside that cycle the
// result ports carry intermediate values. A new transaction may be started
// in the same cycle as done_o. Every division and every Euclid remainder
// step goes through the bit-serial divider, so multiply and add with equal
// denominators never wait on it, while simplify and add with differing
// denominators take a data-dependent number of Euclid steps (up to about
// 46 for 32-bit values).
// Divide by zero (or a zero gcd) gives zeros with div_error_o set.
module rational_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] num_a_i,
  input  logic signed [31:0] den_a_i,
  input  logic signed [31:0] num_b_i,
  input  logic signed [31:0] den_b_i,
  output logic               done_o,
  output logic signed [31:0] num_r_o,
  output logic signed [31:0] den_r_o,
  output logic               div_error_o
);

  rau_pkg::state_e state_q, state_d;
  logic [rau_pkg::PcW-1:0] pc_q, pc_d;
  logic done_q, done_d;

  // datapath registers
  logic [rau_pkg::W-1:0] na_q, da_q, nb_q, db_q, ga_q, gb_q, m_q, t_q, nr_q, dr_q;
  logic                  err_q;

  rau_pkg::uword_t       uw;
  logic [rau_pkg::W-1:0] opa, opb, alu_res;
  logic                  accept, is_div, div_start, step_go, cond_hit;
  logic                  fail;
  logic                  div_done;
  logic [rau_pkg::W-1:0] div_quot, div_rem;

  assign accept = start && (state_q == rau_pkg::ST_IDLE);
  assign uw     = rau_pkg::ucode(pc_q);
  assign is_div = (uw.alu == rau_pkg::ALU_DIVQ) || (uw.alu == rau_pkg::ALU_DIVR);

  function automatic logic [rau_pkg::W-1:0] rd(rau_pkg::src_e s,
      logic [rau_pkg::W-1:0] na, logic [rau_pkg::W-1:0] da,
      logic [rau_pkg::W-1:0] nb, logic [rau_pkg::W-1:0] db,
      logic [rau_pkg::W-1:0] ga, logic [rau_pkg::W-1:0] gb,
      logic [rau_pkg::W-1:0] m,  logic [rau_pkg::W-1:0] t,
      logic [rau_pkg::W-1:0] nr);
    logic [rau_pkg::W-1:0] v;
    unique case (s)
      rau_pkg::SRC_NA:  v = na;
      rau_pkg::SRC_DA:  v = da;
      rau_pkg::SRC_NB:  v = nb;
      rau_pkg::SRC_DB:  v = db;
      rau_pkg::SRC_GA:  v = ga;
      rau_pkg::SRC_GB:  v = gb;
      rau_pkg::SRC_M:   v = m;
      rau_pkg::SRC_T:   v = t;
      rau_pkg::SRC_NR:  v = nr;
      rau_pkg::SRC_ONE: v = rau_pkg::W'(1);
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign opa = rd(uw.srca, na_q, da_q, nb_q, db_q, ga_q, gb_q, m_q, t_q, nr_q);
  assign opb = rd(uw.srcb, na_q, da_q, nb_q, db_q, ga_q, gb_q, m_q, t_q, nr_q);

  // ALU: pass, add, low half of product, or divider result
  always_comb begin
    case (uw.alu)
      rau_pkg::ALU_PASS: alu_res = opa;
      rau_pkg::ALU_ADD:  alu_res = opa + opb;
      rau_pkg::ALU_MUL:  alu_res = opa * opb;
      rau_pkg::ALU_DIVQ: alu_res = div_quot;
      rau_pkg::ALU_DIVR: alu_res = div_rem;
      default:           alu_res = '0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      rau_pkg::C_EQ:   cond_hit = (opa == opb);
      rau_pkg::C_ZERO: cond_hit = (opa == '0);
      rau_pkg::C_ANYZ: cond_hit = (opa == '0) || (opb == '0);
      rau_pkg::C_GOTO: cond_hit = 1'b1;
      default:         cond_hit = 1'b0;
    endcase
  end

  // sequencer: next state, next pc, step strobes
  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    done_d    = 1'b0;
    div_start = 1'b0;
    step_go   = 1'b0;
    fail      = 1'b0;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        if (start) begin
          state_d = rau_pkg::ST_RUN;
          pc_d    = rau_pkg::entry(op_i);
        end
      end
      rau_pkg::ST_RUN: begin
        if (is_div) begin
          div_start = 1'b1;
          state_d   = rau_pkg::ST_WAIT;
        end else begin
          step_go = 1'b1;
        end
      end
      rau_pkg::ST_WAIT: begin
        if (div_done) begin
          step_go = 1'b1;
          state_d = rau_pkg::ST_RUN;
        end
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
    if (step_go) begin
      if (uw.cond == rau_pkg::C_FIN || uw.cond == rau_pkg::C_FAIL) begin
        fail    = (uw.cond == rau_pkg::C_FAIL);
        done_d  = 1'b1;
        state_d = rau_pkg::ST_IDLE;
      end else if (cond_hit) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
      pc_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      na_q  <= num_a_i;
      da_q  <= den_a_i;
      nb_q  <= num_b_i;
      db_q  <= den_b_i;
      err_q <= 1'b0;
    end
    if (step_go) begin
      case (uw.dst)
        rau_pkg::DST_GA: ga_q <= alu_res;
        rau_pkg::DST_GB: gb_q <= alu_res;
        rau_pkg::DST_M:  m_q  <= alu_res;
        rau_pkg::DST_T:  t_q  <= alu_res;
        rau_pkg::DST_NR: nr_q <= alu_res;
        rau_pkg::DST_DR: dr_q <= alu_res;
        default: ;
      endcase
      if (uw.swap) begin
        ga_q <= gb_q;
      end
    end
    if (fail) begin
      nr_q  <= '0;
      dr_q  <= '0;
      err_q <= 1'b1;
    end
  end

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (opa),
    .divisor_i  (opb),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign busy        = (state_q != rau_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign num_r_o     = $signed(nr_q);
  assign den_r_o     = $signed(dr_q);
  assign div_error_o = err_q;

  // result strobe only appears once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // strobe is a single-cycle pulse per transaction
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // error results are zeroed
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_error_o) |-> (nr_q == '0 && dr_q == '0))
    else $error("error result not zero");

  // a divider launch always parks the sequencer in the wait state
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == rau_pkg::ST_WAIT)) else $error("divider launch lost");

  // accepted transaction makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("transaction accepted but not busy");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rational_arithmetic_unit: directed corner cases, then
// random transactions, checked against a built-in predictor. Depends on rau_pkg and the RTL.
module testbench;

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        err;
  } fraction_t;

  // A result still owed by the block, tagged for reporting.
  typedef struct {
    int unsigned id;
    logic [1:0]  op;
    fraction_t   res;
  } owed_result_t;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainCycles = 256;
  localparam logic [31:0] IntMin = 32'h8000_0000;
  localparam logic [31:0] IntMax = 32'h7fff_ffff;
  localparam logic [31:0] MinusOne = 32'hffff_ffff;
  // Consecutive Fibonacci numbers: the longest Euclid chain in 32 bits.
  localparam logic [31:0] FibHi = 32'd1836311903;
  localparam logic [31:0] FibLo = 32'd1134903170;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         op_i = rau_pkg::OP_ADD;
  logic signed [31:0] num_a_i = '0;
  logic signed [31:0] den_a_i = '0;
  logic signed [31:0] num_b_i = '0;
  logic signed [31:0] den_b_i = '0;
  logic               busy;
  logic               done_o;
  logic signed [31:0] num_r_o;
  logic signed [31:0] den_r_o;
  logic               div_error_o;

  owed_result_t owed_q[$];
  int unsigned  sent_count = 0;
  int unsigned  op_count[4] = '{0, 0, 0, 0};
  int unsigned  error_results = 0;
  int unsigned  mismatches = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  sender_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  rational_arithmetic_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .num_a_i    (num_a_i),
    .den_a_i    (den_a_i),
    .num_b_i    (num_b_i),
    .den_b_i    (den_b_i),
    .done_o     (done_o),
    .num_r_o    (num_r_o),
    .den_r_o    (den_r_o),
    .div_error_o(div_error_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic on raw 32-bit patterns, wrapping two's complement.
  // Division truncates toward zero; remainder takes the sign of the dividend,
  // so the gcd can come out negative and that sign propagates into the result.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] magnitude(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = magnitude(a) / magnitude(b);
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] trunc_remainder(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    r = magnitude(a) % magnitude(b);
    return a[31] ? -r : r;
  endfunction

  function automatic logic [31:0] euclid_gcd(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != '0) begin
      t = b;
      b = trunc_remainder(a, b);
      a = t;
    end
    return a;
  endfunction

  function automatic fraction_t predict_fraction(logic [1:0] op, logic [31:0] na,
                                                 logic [31:0] da, logic [31:0] nb,
                                                 logic [31:0] db);
    fraction_t   r;
    logic [31:0] g;
    logic [31:0] lcm;
    r = '0;
    case (op)
      rau_pkg::OP_ADD: begin
        // equal denominators skip all division, even when both are zero
        if (da == db) begin
          r.num = na + nb;
          r.den = da;
        end else if (da == '0 || db == '0) begin
          r.err = 1'b1;
        end else begin
          g = euclid_gcd(da, db);
          lcm = trunc_quotient(da * db, g);
          r.num = na * trunc_quotient(lcm, da) + nb * trunc_quotient(lcm, db);
          r.den = lcm;
        end
      end
      rau_pkg::OP_MUL: begin
        r.num = na * nb;
        r.den = da * db;
      end
      rau_pkg::OP_SIMP: begin
        g = euclid_gcd(na, da);
        if (g == '0) begin
          r.err = 1'b1;
        end else begin
          r.num = trunc_quotient(na, g);
          r.den = trunc_quotient(da, g);
        end
      end
      default: begin
        if (da == '0) begin
          r.err = 1'b1;
        end else begin
          r.num = trunc_quotient(na, da);
          r.den = 32'd1;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Fields and start change only at rising edges (nonblocking). start
  // stays up across back-to-back transactions; the transaction is taken at the
  // first edge with busy low. An optional idle gap follows acceptance, so start
  // sees a single assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [31:0] na,
                           input logic [31:0] da, input logic [31:0] nb,
                           input logic [31:0] db);
    start   <= 1'b1;
    op_i    <= op;
    num_a_i <= na;
    den_a_i <= da;
    num_b_i <= nb;
    den_b_i <= db;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    owed_q.push_back('{sent_count, op, predict_fraction(op, na, da, nb, db)});
    sent_count++;
    op_count[op]++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. done_o is a one-cycle strobe with no back-pressure, so every
  // edge with done_o high carries a result that must match the oldest owed one.
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, owed_result_t owed, fraction_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] %s: id %0d op %0d exp num %0d den %0d err %0b, got num %0d den %0d err %0b",
               $time, what, owed.id, owed.op, $signed(owed.res.num), $signed(owed.res.den),
               owed.res.err, $signed(got.num), $signed(got.den), got.err);
  endfunction

  always @(posedge clk_i) begin : result_check
    fraction_t    got;
    owed_result_t owed;
    if (rst_ni && done_o) begin
      got = '{num_r_o, den_r_o, div_error_o};
      if (owed_q.size() == 0) begin
        owed = '{0, rau_pkg::OP_ADD, '0};
        flag_mismatch("result with nothing owed", owed, got);
      end else begin
        owed = owed_q.pop_front();
        if (got.err) error_results++;
        if (got.num !== owed.res.num || got.den !== owed.res.den || got.err !== owed.res.err)
          flag_mismatch("result mismatch", owed, got);
      end
    end
  end

  // Watchdog: counts cycles with work outstanding but no transaction moving.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (!start && owed_q.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("[%0t] timeout with %0d results owed", $time, owed_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_multiply_edges();
    send_item(rau_pkg::OP_MUL, IntMin, 32'd1, MinusOne, 32'd1);  // wraps to most negative
    send_item(rau_pkg::OP_MUL, IntMax, IntMax, IntMax, 32'd0);   // zero den passes through
    send_item(rau_pkg::OP_MUL, 32'd0, 32'd0, 32'd5, 32'd0);
    send_item(rau_pkg::OP_MUL, -32'sd3, 32'd7, 32'd5, -32'sd2);
  endtask

  task automatic test_add_edges();
    send_item(rau_pkg::OP_ADD, IntMax, 32'd4, 32'd1, 32'd4);      // shared den, sum wraps
    send_item(rau_pkg::OP_ADD, 32'd3, 32'd0, 32'd5, 32'd0);       // both dens zero: no error
    send_item(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd3);       // one zero den
    send_item(rau_pkg::OP_ADD, 32'd1, 32'd3, 32'd1, 32'd0);
    send_item(rau_pkg::OP_ADD, 32'd1, 32'd6, 32'd1, 32'd4);
    send_item(rau_pkg::OP_ADD, MinusOne, -32'sd6, 32'd2, 32'd9);  // negative den gives negative lcm
    send_item(rau_pkg::OP_ADD, 32'd1, FibHi, MinusOne, FibLo);    // longest gcd, wraps
    send_item(rau_pkg::OP_ADD, IntMin, IntMin, IntMax, IntMax);
  endtask

  task automatic test_simplify_edges();
    send_item(rau_pkg::OP_SIMP, 32'd0, 32'd0, $urandom(), $urandom());  // zero gcd
    send_item(rau_pkg::OP_SIMP, 32'd0, 32'd5, $urandom(), $urandom());
    send_item(rau_pkg::OP_SIMP, 32'd6, -32'sd4, $urandom(), $urandom());
    send_item(rau_pkg::OP_SIMP, IntMin, MinusOne, $urandom(), $urandom());
    send_item(rau_pkg::OP_SIMP, FibHi, FibLo, $urandom(), $urandom());
    send_item(rau_pkg::OP_SIMP, IntMin, 32'd0, $urandom(), $urandom());
    send_item(rau_pkg::OP_SIMP, IntMax, IntMin, $urandom(), $urandom());
  endtask

  task automatic test_quotient_edges();
    send_item(rau_pkg::OP_QUOT, 32'd5, 32'd0, $urandom(), $urandom());     // divide by zero
    send_item(rau_pkg::OP_QUOT, IntMin, MinusOne, $urandom(), $urandom()); // overflow wraps
    send_item(rau_pkg::OP_QUOT, 32'd7, -32'sd2, $urandom(), $urandom());
    send_item(rau_pkg::OP_QUOT, -32'sd7, 32'd2, $urandom(), $urandom());
    send_item(rau_pkg::OP_QUOT, IntMax, 32'd1, $urandom(), $urandom());
    send_item(rau_pkg::OP_QUOT, IntMin, IntMax, $urandom(), $urandom());
  endtask

  // Operand mix: mostly small or factor-rich values so gcds are nontrivial and
  // Euclid chains stay short; some full-width and extreme values.
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(9)) inside
      [0:3]: v = $urandom_range(200) - 100;
      [4:5]: begin
        v = $urandom_range(1000) << $urandom_range(12);
        if ($urandom_range(1)) v = -v;
      end
      [6:7]: v = $urandom();
      8: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 32'd1;
          2: v = MinusOne;
          3: v = IntMin;
          default: v = IntMax;
        endcase
      end
      default: v = $urandom() >> $urandom_range(31);
    endcase
    return v;
  endfunction

  task automatic test_random_mix(input int unsigned count, input int unsigned idle_pct);
    logic [1:0]  op;
    logic [31:0] da;
    logic [31:0] db;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      op = 2'($urandom_range(3));
      da = random_operand();
      db = ($urandom_range(9) < 3) ? da : random_operand();  // shared-den adds
      send_item(op, random_operand(), da, random_operand(), db);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed corners back to back, then four random
  // phases with sender idle rates of 0, 85, 28 and 0 percent, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_multiply_edges();
    test_add_edges();
    test_simplify_edges();
    test_quotient_edges();
    test_random_mix(240, 0);
    test_random_mix(240, 85);
    test_random_mix(240, 28);
    test_random_mix(230, 0);
    start <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);  // catch any stray strobe
    $display("Ran %0d transactions: %0d add, %0d multiply, %0d simplify, %0d quotient",
             sent_count, op_count[rau_pkg::OP_ADD], op_count[rau_pkg::OP_MUL],
             op_count[rau_pkg::OP_SIMP], op_count[rau_pkg::OP_QUOT]);
    $display("%0d results carried a divide error; %0d mismatches", error_results, mismatches);
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/rau_pkg.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
test/testbench.sv
